// ===== rtl/pmix_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmix_pkg - shared types, constants and arithmetic for the pan mixer
// Voice entry layout, command and state codes, fold divider by 127 and
// 16-bit saturation.
// ----------------------------------------------------------------------------
package pmix_pkg;

  localparam int VOICES       = 8;
  localparam int SAMPLE_DEPTH = 65536;   // power of two, addresses wrap

  localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SAMP_AW  = $clog2(SAMPLE_DEPTH);

  localparam logic [VOICE_AW-1:0] LAST_VOICE = VOICE_AW'(VOICES - 1);

  localparam logic [7:0]         SEP_MAX  = 8'd254;
  localparam logic [7:0]         FOLD_LIM = 8'd127;
  localparam logic signed [17:0] SAT_MAX  = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN  = -18'sd32768;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_START  = 3'd1,
    CMD_PARAMS = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_APPLY,
    ST_TICK,
    ST_DRAIN
  } state_e;

  // gains are stored pre-divided by 254
  typedef struct packed {
    logic [6:0]  gain_l;
    logic [6:0]  gain_r;
    logic [15:0] pos;
    logic [15:0] len;
    logic [15:0] base;
  } voice_ent_t;

  typedef struct packed {
    logic       vld;
    logic       last;
    logic       act;
    logic [6:0] gain_l;
    logic [6:0] gain_r;
  } scale_in_t;

  // floor(m/127): m = 128a + b gives m/127 = a + (a+b)/127, folded three times
  function automatic logic [15:0] div127(input logic [21:0] m);
    logic [14:0] a1;
    logic [15:0] n1;
    logic [8:0]  a2;
    logic [9:0]  n2;
    logic [2:0]  a3;
    logic [7:0]  n3;
    logic [15:0] q;
    a1 = m[21:7];
    n1 = {1'b0, a1} + {9'd0, m[6:0]};
    a2 = n1[15:7];
    n2 = {1'b0, a2} + {3'd0, n1[6:0]};
    a3 = n2[9:7];
    n3 = {5'd0, a3} + {1'b0, n2[6:0]};
    q  = {1'b0, a1} + {7'd0, a2} + {13'd0, a3} + {15'd0, (n3 >= FOLD_LIM)};
    return q;
  endfunction

  // signed divide by 127, truncating toward zero
  function automatic logic signed [16:0] sdiv127(input logic signed [23:0] p);
    logic [23:0] mag;
    logic [15:0] q;
    mag = p[23] ? 24'(-p) : 24'(p);
    q   = div127(mag[21:0]);
    return p[23] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (x < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/multichannel_pan_mixer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_pan_mixer_unit - eight-voice sample mixer with stereo pan
// Sample memory, voice table, command sequencer and tick pipeline.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low. Write, start, set
// params, stop and unused codes keep busy high through a prepare state (a
// voice table read) and an apply state (the write back, if any). A tick keeps
// busy high while the voice table is read once per voice, one voice a cycle,
// and while the sample read, multiply, divide and accumulate stages drain.
// The result beat (done with left_out, right_out, active_mask) appears for
// one cycle, in the first cycle with busy low, and cannot be held off. The
// sample memory is not cleared: read only what was written.
// ----------------------------------------------------------------------------
module multichannel_pan_mixer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         cmd,
  input  logic [2:0]         voice,
  input  logic [6:0]         volume,
  input  logic [7:0]         separation,
  input  logic [15:0]        sample_address,
  input  logic [15:0]        sound_length,
  input  logic signed [15:0] sample_value,
  output logic               busy,
  output logic               done,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic [7:0]         active_mask
);

  import pmix_pkg::*;

  state_e state, state_next;

  logic                accept, tick_go;
  logic [2:0]          c_cmd, c_voice;
  logic [6:0]          c_vol;
  logic [7:0]          c_sep;
  logic [15:0]         c_addr, c_len, c_val;
  logic                c_voice_ok;
  logic [VOICE_AW-1:0] c_vidx;
  logic [14:0]         gprod_l, gprod_r;
  logic [15:0]         gq_l, gq_r;

  logic [VOICE_AW-1:0] tick_idx;
  logic [VOICES-1:0]   active;
  logic [31:0]         active_ext;

  logic                s0_vld, s0_last, s0_act, s0_step;
  logic [VOICE_AW-1:0] s0_idx;
  scale_in_t           s1;
  logic [15:0]         pos_inc;
  logic                fin;

  logic                vram_we;
  logic [VOICE_AW-1:0] vram_waddr, vram_raddr;
  voice_ent_t          vram_wdata, vram_rdata;
  logic                sram_we;
  logic [SAMP_AW-1:0]  sram_waddr, sram_raddr;
  logic [15:0]         sram_rdata;

  assign accept     = start && !busy;
  assign tick_go    = accept && (cmd == CMD_TICK);
  assign c_voice_ok = (int'(c_voice) < VOICES);
  assign c_vidx     = VOICE_AW'(c_voice);
  assign active_ext = 32'(active);
  assign s0_step    = s0_vld && s0_act;
  assign pos_inc    = vram_rdata.pos + 16'd1;
  assign gq_l       = div127(22'(gprod_l[14:1]));
  assign gq_r       = div127(22'(gprod_r[14:1]));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = (cmd == CMD_TICK) ? ST_TICK : ST_PREP;
      ST_PREP:  state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      ST_TICK:  if (tick_idx == LAST_VOICE) state_next = ST_DRAIN;
      ST_DRAIN: if (fin) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    vram_raddr = (state == ST_TICK) ? tick_idx : c_vidx;
    vram_we    = 1'b0;
    vram_waddr = c_vidx;
    vram_wdata = vram_rdata;
    sram_we    = 1'b0;
    if (state == ST_APPLY) begin
      unique case (c_cmd)
        CMD_WRITE: sram_we = 1'b1;
        CMD_START: begin
          vram_we    = c_voice_ok;
          vram_wdata = '{gain_l: gq_l[6:0], gain_r: gq_r[6:0], pos: 16'd0,
                         len: c_len, base: c_addr};
        end
        CMD_PARAMS: begin
          vram_we           = c_voice_ok;
          vram_wdata.gain_l = gq_l[6:0];
          vram_wdata.gain_r = gq_r[6:0];
        end
        default: ;
      endcase
    end else if (s0_step) begin
      vram_we        = 1'b1;
      vram_waddr     = s0_idx;
      vram_wdata.pos = pos_inc;
    end
  end

  // ---------------- command capture ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      c_cmd   <= cmd;
      c_voice <= voice;
      c_vol   <= volume;
      c_sep   <= (separation > SEP_MAX) ? SEP_MAX : separation;
      c_addr  <= sample_address;
      c_len   <= sound_length;
      c_val   <= sample_value;
    end
    gprod_l <= 15'(c_vol) * 15'(SEP_MAX - c_sep);
    gprod_r <= 15'(c_vol) * 15'(c_sep);
  end

  // ---------------- voice walk ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_idx <= '0;
    end else if (tick_go) begin
      tick_idx <= '0;
    end else if (state == ST_TICK && tick_idx != LAST_VOICE) begin
      tick_idx <= tick_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1.vld <= 1'b0;
    end else begin
      s0_vld <= (state == ST_TICK);
      s1.vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx    <= tick_idx;
    s0_act    <= active[tick_idx];
    s0_last   <= (tick_idx == LAST_VOICE);
    s1.last   <= s0_last;
    s1.act    <= s0_act;
    s1.gain_l <= vram_rdata.gain_l;
    s1.gain_r <= vram_rdata.gain_r;
  end

  // voice goes quiet once pos reaches len
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (state == ST_APPLY && c_voice_ok && c_cmd == CMD_START) begin
      active[c_vidx] <= (c_len != 16'd0);
    end else if (state == ST_APPLY && c_voice_ok && c_cmd == CMD_STOP) begin
      active[c_vidx] <= 1'b0;
    end else if (s0_step) begin
      active[s0_idx] <= (pos_inc < vram_rdata.len);
    end
  end

  assign sram_waddr = SAMP_AW'(c_addr);
  assign sram_raddr = SAMP_AW'({1'b0, vram_rdata.base} + {1'b0, vram_rdata.pos});

  // ---------------- memories ----------------
  pmix_ram #(
    .WIDTH ($bits(voice_ent_t)),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  pmix_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (c_val),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  pmix_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_s        (s1),
    .sample      ($signed(sram_rdata)),
    .clear       (tick_go),
    .mask_in     (active_ext[7:0]),
    .fin         (fin),
    .done        (done),
    .left_out    (left_out),
    .right_out   (right_out),
    .active_mask (active_mask)
  );

  // ---------------- assertions ----------------
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after command beat");

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == ST_DRAIN) && !busy))
    else $error("result beat outside tick drain");

  a_sram_we_apply: assert property (@(posedge clk) disable iff (rst)
    sram_we |-> (state == ST_APPLY))
    else $error("sample write outside command apply");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> !s0_vld)
    else $error("voice table write clash between command and tick");

  a_step_in_tick: assert property (@(posedge clk) disable iff (rst)
    s0_step |-> (state == ST_TICK || state == ST_DRAIN))
    else $error("voice advance outside a tick");

endmodule
`default_nettype wire

// ===== rtl/pmix_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmix_ram - generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pmix_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pmix_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmix_scale - per-voice scaling and stereo accumulation
// Multiply by gain, divide by 127 toward zero, saturating add per side;
// issues the tick result after the last voice beat.
// ----------------------------------------------------------------------------
module pmix_scale (
  input  logic                clk,
  input  logic                rst,
  input  pmix_pkg::scale_in_t in_s,
  input  logic signed [15:0]  sample,
  input  logic                clear,
  input  logic [7:0]          mask_in,
  output logic                fin,
  output logic                done,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out,
  output logic [7:0]          active_mask
);

  import pmix_pkg::*;

  logic signed [23:0] prod_l, prod_r;
  logic               a_vld, a_last, a_act;
  logic signed [23:0] a_pl, a_pr;
  logic               b_vld, b_last, b_act;
  logic signed [16:0] b_ql, b_qr;
  logic signed [15:0] acc_l, acc_r;
  logic signed [17:0] sum_l, sum_r;

  assign prod_l = sample * $signed({1'b0, in_s.gain_l});
  assign prod_r = sample * $signed({1'b0, in_s.gain_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= in_s.vld;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_last <= in_s.last;
    a_act  <= in_s.act;
    a_pl   <= prod_l;
    a_pr   <= prod_r;
    b_last <= a_last;
    b_act  <= a_act;
    b_ql   <= sdiv127(a_pl);
    b_qr   <= sdiv127(a_pr);
  end

  // inactive voices add nothing
  assign sum_l = 18'(acc_l) + (b_act ? 18'(b_ql) : 18'sd0);
  assign sum_r = 18'(acc_r) + (b_act ? 18'(b_qr) : 18'sd0);
  assign fin   = b_vld && b_last;

  always_ff @(posedge clk) begin
    if (clear) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (b_vld) begin
      acc_l <= sat16(sum_l);
      acc_r <= sat16(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      left_out    <= sat16(sum_l);
      right_out   <= sat16(sum_r);
      active_mask <= mask_in;
    end
  end

endmodule
`default_nettype wire

// ===== tb/pan_mix_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pan_mix_checker - mix prediction and result check for the pan mixer
// Watches the command and result beats, keeps its own voice table and sample
// memory, works out each tick's mix and compares it with the result beat.
// ----------------------------------------------------------------------------
module pan_mix_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd,
  input  logic [2:0]         voice,
  input  logic [6:0]         volume,
  input  logic [7:0]         separation,
  input  logic [15:0]        sample_address,
  input  logic [15:0]        sound_length,
  input  logic signed [15:0] sample_value,
  input  logic               done,
  input  logic signed [15:0] left_out,
  input  logic signed [15:0] right_out,
  input  logic [7:0]         active_mask,
  output int                 fail_count,
  output int                 n_wait
);
  import pmix_pkg::*;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  mask;
  } mix_t;

  logic        v_on   [VOICES];
  logic [6:0]  v_vol  [VOICES];
  logic [7:0]  v_pan  [VOICES];
  logic [15:0] v_pos  [VOICES];
  logic [15:0] v_len  [VOICES];
  logic [15:0] v_base [VOICES];
  logic [15:0] smem   [SAMPLE_DEPTH];

  mix_t mixes_due [$];
  int   errs = 0;

  function automatic int clip16(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // one tick: walk the voices in order, saturating after each one
  task automatic mix_voices(output mix_t r);
    int          acc_l;
    int          acc_r;
    int          smp;
    int          g_l;
    int          g_r;
    logic [15:0] a;
    acc_l = 0;
    acc_r = 0;
    r     = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (v_on[i]) begin
        a     = v_base[i] + v_pos[i];
        smp   = $signed(smem[a]);
        g_l   = int'(v_vol[i]) * (int'(SEP_MAX) - int'(v_pan[i])) / int'(SEP_MAX);
        g_r   = int'(v_vol[i]) * int'(v_pan[i]) / int'(SEP_MAX);
        acc_l = clip16(acc_l + smp * g_l / int'(FOLD_LIM));
        acc_r = clip16(acc_r + smp * g_r / int'(FOLD_LIM));
        v_pos[i] = v_pos[i] + 16'd1;
        if (v_pos[i] >= v_len[i]) v_on[i] = 1'b0;
      end
    end
    for (int i = 0; i < VOICES && i < 8; i++) begin
      if (v_on[i]) r.mask[i] = 1'b1;
    end
    r.left  = acc_l[15:0];
    r.right = acc_r[15:0];
  endtask

  always @(posedge clk) begin : watch
    mix_t       want;
    logic [7:0] pan;
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        v_on[i]   = 1'b0;
        v_vol[i]  = '0;
        v_pan[i]  = '0;
        v_pos[i]  = '0;
        v_len[i]  = '0;
        v_base[i] = '0;
      end
      mixes_due.delete();
    end else begin
      // result beat first: a new command may be taken on the same edge
      if (done) begin
        if (mixes_due.size() == 0) begin
          errs++;
          $display("%0t unexpected mix beat: expected none, got left %0d right %0d mask %h",
                   $time, left_out, right_out, active_mask);
        end else begin
          want = mixes_due.pop_front();
          if (want.left !== left_out) begin
            errs++;
            $display("%0t left_out: expected %0d, got %0d", $time, $signed(want.left),
                     left_out);
          end
          if (want.right !== right_out) begin
            errs++;
            $display("%0t right_out: expected %0d, got %0d", $time, $signed(want.right),
                     right_out);
          end
          if (want.mask !== active_mask) begin
            errs++;
            $display("%0t active_mask: expected %h, got %h", $time, want.mask, active_mask);
          end
        end
      end
      if (start && !busy) begin
        pan = (separation > SEP_MAX) ? SEP_MAX : separation;
        case (cmd)
          CMD_WRITE: smem[sample_address] = sample_value;
          CMD_START: begin
            if (int'(voice) < VOICES) begin
              v_vol[voice]  = volume;
              v_pan[voice]  = pan;
              v_pos[voice]  = '0;
              v_len[voice]  = sound_length;
              v_base[voice] = sample_address;
              v_on[voice]   = (sound_length != 16'd0);
            end
          end
          CMD_PARAMS: begin
            if (int'(voice) < VOICES) begin
              v_vol[voice] = volume;
              v_pan[voice] = pan;
            end
          end
          CMD_STOP: begin
            if (int'(voice) < VOICES) v_on[voice] = 1'b0;
          end
          CMD_TICK: begin
            mix_voices(want);
            mixes_due.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    n_wait     <= mixes_due.size();
  end

endmodule
`default_nettype wire

// ===== tb/multichannel_pan_mixer_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_pan_mixer_unit_tb - stimulus and verdict for the pan mixer
// Directed commands over the corner cases, then random command streams in
// phases of differing sender gaps; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module multichannel_pan_mixer_unit_tb;
  import pmix_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int N_RANDOM    = 2000;
  localparam int MAX_GAP     = 20;

  logic               clk;
  logic               rst;
  logic               start;
  logic [2:0]         cmd;
  logic [2:0]         voice;
  logic [6:0]         volume;
  logic [7:0]         separation;
  logic [15:0]        sample_address;
  logic [15:0]        sound_length;
  logic signed [15:0] sample_value;
  logic               busy;
  logic               done;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic [7:0]         active_mask;
  int                 fail_count;
  int                 n_wait;

  int cycles   = 0;
  int idle_pct = 0;
  int n_items  = 0;
  // results cannot be held off, so the receiver phases add no gaps
  int idle_rate [4] = '{0, 56, 0, 21};

  // where each voice is reading, so no tick reads unwritten memory
  bit          written [SAMPLE_DEPTH];
  logic        pl_on   [VOICES];
  logic [15:0] pl_pos  [VOICES];
  logic [15:0] pl_len  [VOICES];
  logic [15:0] pl_base [VOICES];

  multichannel_pan_mixer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .voice          (voice),
    .volume         (volume),
    .separation     (separation),
    .sample_address (sample_address),
    .sound_length   (sound_length),
    .sample_value   (sample_value),
    .busy           (busy),
    .done           (done),
    .left_out       (left_out),
    .right_out      (right_out),
    .active_mask    (active_mask)
  );

  pan_mix_checker chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .voice          (voice),
    .volume         (volume),
    .separation     (separation),
    .sample_address (sample_address),
    .sound_length   (sound_length),
    .sample_value   (sample_value),
    .done           (done),
    .left_out       (left_out),
    .right_out      (right_out),
    .active_mask    (active_mask),
    .fail_count     (fail_count),
    .n_wait         (n_wait)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL multichannel_pan_mixer_unit");
      $finish;
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic issue_cmd(input logic [2:0] c, input logic [2:0] v, input logic [6:0] vol,
                           input logic [7:0] sep, input logic [15:0] addr,
                           input logic [15:0] len, input logic [15:0] val);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
      gap++;
    end
    cmd            = c;
    voice          = v;
    volume         = vol;
    separation     = sep;
    sample_address = addr;
    sound_length   = len;
    sample_value   = val;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    @(negedge clk);
  endtask

  task automatic put_sample(input logic [15:0] addr, input logic [15:0] val);
    issue_cmd(CMD_WRITE, 3'($urandom), 7'($urandom), 8'($urandom), addr, 16'($urandom), val);
    written[addr] = 1'b1;
  endtask

  task automatic start_voice(input logic [2:0] v, input logic [6:0] vol, input logic [7:0] sep,
                             input logic [15:0] base, input logic [15:0] len);
    issue_cmd(CMD_START, v, vol, sep, base, len, 16'($urandom));
    pl_on[v]   = (len != 16'd0);
    pl_pos[v]  = '0;
    pl_len[v]  = len;
    pl_base[v] = base;
  endtask

  task automatic set_pan(input logic [2:0] v, input logic [6:0] vol, input logic [7:0] sep);
    issue_cmd(CMD_PARAMS, v, vol, sep, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic stop_voice(input logic [2:0] v);
    issue_cmd(CMD_STOP, v, 7'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    pl_on[v] = 1'b0;
  endtask

  task automatic unused_cmd(input logic [2:0] c);
    issue_cmd(c, 3'($urandom), 7'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic mix_tick();
    logic [15:0] a;
    // fill any sample a voice is about to read
    for (int i = 0; i < VOICES; i++) begin
      if (pl_on[i]) begin
        a = pl_base[i] + pl_pos[i];
        if (!written[a]) put_sample(a, rand_sample());
      end
    end
    issue_cmd(CMD_TICK, 3'($urandom), 7'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
    for (int i = 0; i < VOICES; i++) begin
      if (pl_on[i]) begin
        pl_pos[i] = pl_pos[i] + 16'd1;
        if (pl_pos[i] >= pl_len[i]) pl_on[i] = 1'b0;
      end
    end
  endtask

  initial begin : stim
    int          r;
    int          r2;
    int          phase;
    logic [2:0]  v;
    logic [6:0]  vol;
    logic [7:0]  sep;
    logic [15:0] base;
    logic [15:0] len;
    start          = 1'b0;
    cmd            = '0;
    voice          = '0;
    volume         = '0;
    separation     = '0;
    sample_address = '0;
    sound_length   = '0;
    sample_value   = '0;
    rst            = 1'b1;
    phase          = -1;
    for (int i = 0; i < VOICES; i++) begin
      pl_on[i]   = 1'b0;
      pl_pos[i]  = '0;
      pl_len[i]  = '0;
      pl_base[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: quiet tick, address wrap, separation saturation, zero length,
    // params on an inactive voice, unused codes, long sound then stop
    mix_tick();
    put_sample(16'hffff, 16'h7fff);
    put_sample(16'h0000, 16'h8000);
    put_sample(16'h0001, 16'hffff);
    start_voice(3'd0, 7'd127, 8'd0, 16'hffff, 16'd3);
    start_voice(3'd7, 7'd127, 8'hff, 16'hffff, 16'd2);
    start_voice(3'd3, 7'd100, 8'd127, 16'h0000, 16'd0);
    mix_tick();
    set_pan(3'd0, 7'd0, 8'd127);
    set_pan(3'd5, 7'd127, 8'd200);
    mix_tick();
    unused_cmd(3'd5);
    unused_cmd(3'd7);
    mix_tick();
    start_voice(3'd1, 7'd127, SEP_MAX, 16'h0000, 16'hffff);
    mix_tick();
    stop_voice(3'd1);
    mix_tick();

    // fills issued ahead of a tick count as beats too
    while (n_items < N_RANDOM) begin
      if (n_items * 4 / N_RANDOM != phase) begin
        // let every beat drain before the next phase
        start = 1'b0;
        while (n_wait != 0) @(posedge clk);
        @(negedge clk);
        phase    = n_items * 4 / N_RANDOM;
        idle_pct = idle_rate[phase];
      end
      r  = $urandom_range(99);
      r2 = $urandom_range(99);
      v  = 3'($urandom);
      if (r < 30) begin
        mix_tick();
      end else if (r < 55) begin
        if (r2 < 50) base = pl_base[v] + pl_pos[v] + 16'($urandom_range(7));
        else base = 16'($urandom);
        put_sample(base, rand_sample());
      end else if (r < 73) begin
        vol  = (r2 < 20) ? 7'd127 : (r2 < 30) ? 7'd0 : 7'($urandom);
        r2   = $urandom_range(99);
        sep  = (r2 < 15) ? 8'd0 : (r2 < 30) ? SEP_MAX : (r2 < 35) ? 8'hff : 8'($urandom);
        base = ($urandom_range(9) == 0) ? 16'hfff0 + 16'($urandom_range(15)) : 16'($urandom);
        r2   = $urandom_range(99);
        len  = (r2 < 10) ? 16'd0 : (r2 < 15) ? 16'($urandom) : 16'($urandom_range(48, 1));
        start_voice(v, vol, sep, base, len);
      end else if (r < 85) begin
        vol = (r2 < 20) ? 7'd127 : (r2 < 30) ? 7'd0 : 7'($urandom);
        r2  = $urandom_range(99);
        sep = (r2 < 15) ? 8'd0 : (r2 < 30) ? SEP_MAX : (r2 < 35) ? 8'hff : 8'($urandom);
        set_pan(v, vol, sep);
      end else if (r < 93) begin
        stop_voice(v);
      end else begin
        unused_cmd(3'($urandom_range(7, 5)));
      end
    end

    start = 1'b0;
    while (n_wait != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && n_wait == 0) begin
      $display("PASS multichannel_pan_mixer_unit");
    end else begin
      $display("FAIL multichannel_pan_mixer_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/pmix_pkg.sv
rtl/pmix_ram.sv
rtl/pmix_scale.sv
rtl/multichannel_pan_mixer_unit.sv
tb/pan_mix_checker.sv
tb/multichannel_pan_mixer_unit_tb.sv
